// ----- sv/sha1_pkg.sv -----
// SHA-1 engine shared package: payload structs, state enums, constants, round functions.
// No dependencies; every module of the engine imports it.
package sha1_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int BLOCK_WORDS  = 16;
   localparam int ROUND_COUNT  = 80;
   localparam int DIGEST_WORDS = 5;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;

   localparam logic [31:0] H_INIT [0:DIGEST_WORDS-1] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] K_STAGE0 = 32'h5a827999;
   localparam logic [31:0] K_STAGE1 = 32'h6ed9eba1;
   localparam logic [31:0] K_STAGE2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_STAGE3 = 32'hca62c1d6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } sha1_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha1_rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic        final_word;
   } sha1_word_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MARK,
      FR_ZERO,
      FR_LEN
   } sha1_front_state_type;

   typedef enum logic [1:0] {
      BK_LOAD,
      BK_ROUND,
      BK_ADD,
      BK_EMIT
   } sha1_back_state_type;

   typedef enum logic [1:0] {
      ST_CH,
      ST_PAR1,
      ST_MAJ,
      ST_PAR2
   } sha1_stage_type;

   function automatic logic [31:0] round_f(sha1_stage_type stage, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
      logic [31:0] res;
      unique case (stage)
         ST_CH:   res = (b & c) | (~b & d);
         ST_MAJ:  res = (b & c) | (b & d) | (c & d);
         default: res = b ^ c ^ d;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] round_k(sha1_stage_type stage);
      logic [31:0] res;
      unique case (stage)
         ST_CH:   res = K_STAGE0;
         ST_PAR1: res = K_STAGE1;
         ST_MAJ:  res = K_STAGE2;
         default: res = K_STAGE3;
      endcase
      return res;
   endfunction

endpackage

// ----- sv/sha1_front.sv -----
// SHA-1 front end: takes message bytes, packs big-endian words, appends padding and length.
// Depends on sha1_pkg.
module sha1_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sha1_pkg::sha1_req_type  req_data,
   output logic                  push_valid,
   output sha1_pkg::sha1_word_type push_data,
   input  logic                  push_ready
);
   import sha1_pkg::*;

   sha1_front_state_type state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [23:0] acc_ff, acc_in;
   logic [60:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;

   logic       take;
   logic       byte_en;
   logic [7:0] byte_val;
   logic       final_word;

   // Outputs and byte selection
   always_comb begin
      req_ready  = (state_ff == FR_IDLE) && push_ready;
      take       = req_valid && req_ready;
      byte_en    = 1'b0;
      byte_val   = '0;
      final_word = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            byte_en  = take && req_data.byte_valid;
            byte_val = req_data.data_byte;
         end
         FR_MARK: begin
            byte_en  = push_ready;
            byte_val = PAD_MARK_BYTE;
         end
         FR_ZERO: begin
            byte_en  = push_ready;
         end
         FR_LEN: begin
            byte_en    = push_ready;
            byte_val   = len_ff[63:56];
            final_word = (pos_ff == LAST_BYTE_POS);
         end
      endcase
      push_valid           = byte_en && (pos_ff[1:0] == 2'b11);
      push_data.word       = {acc_ff, byte_val};
      push_data.final_word = final_word;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (take && req_data.end_of_message) state_in = FR_MARK;
         end
         FR_MARK: begin
            if (byte_en) state_in = (pos_in == LEN_FIELD_POS) ? FR_LEN : FR_ZERO;
         end
         FR_ZERO: begin
            if (byte_en && (pos_in == LEN_FIELD_POS)) state_in = FR_LEN;
         end
         FR_LEN: begin
            if (byte_en && (pos_ff == LAST_BYTE_POS)) state_in = FR_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      pos_in   = byte_en ? pos_ff + 6'd1 : pos_ff;
      acc_in   = byte_en ? {acc_ff[15:0], byte_val} : acc_ff;
      count_in = count_ff;
      len_in   = len_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (byte_en) count_in = count_ff + 61'd1;
         end
         FR_MARK: begin
            if (byte_en) len_in = {count_ff, 3'b000};
         end
         FR_ZERO: begin
         end
         FR_LEN: begin
            if (byte_en) len_in = {len_ff[55:0], 8'h00};
            if (byte_en && (pos_ff == LAST_BYTE_POS)) count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      len_ff <= len_in;
   end

endmodule

// ----- sv/sha1_queue.sv -----
// SHA-1 word queue: small FIFO of packed message words between front and back end.
// Depends on sha1_pkg.
module sha1_queue #(
   parameter int Depth = sha1_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  sha1_pkg::sha1_word_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output sha1_pkg::sha1_word_type pop_data
);
   import sha1_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   sha1_word_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   always_comb begin
      push_ready = (cnt_ff != CntW'(Depth));
      pop_valid  = (cnt_ff != '0);
      pop_data   = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;

      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/sha1_back.sv -----
// SHA-1 back end: collects 16-word blocks, runs 80 compression rounds, emits the digest.
// Depends on sha1_pkg.
module sha1_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  sha1_pkg::sha1_word_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sha1_pkg::sha1_rsp_type  rsp_data
);
   import sha1_pkg::*;

   sha1_back_state_type state_ff, state_in;
   logic [31:0]  w_ff     [BLOCK_WORDS];
   logic [31:0]  w_in     [BLOCK_WORDS];
   logic [31:0]  wv_ff    [DIGEST_WORDS];
   logic [31:0]  wv_in    [DIGEST_WORDS];
   logic [31:0]  chain_ff [DIGEST_WORDS];
   logic [31:0]  chain_in [DIGEST_WORDS];
   logic [3:0]   wcnt_ff, wcnt_in;
   logic [6:0]   round_ff, round_in;
   logic [2:0]   idx_ff, idx_in;
   logic         final_ff, final_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sha1_rsp_type rsp_data_ff, rsp_data_in;

   logic           load, emit_load, block_full, round_done, emit_done;
   sha1_stage_type stage;
   logic [31:0]    sched_x, wt, tmp;

   // Handshake outputs and round datapath
   always_comb begin
      pop_ready  = (state_ff == BK_LOAD);
      load       = pop_valid && pop_ready;
      block_full = load && (wcnt_ff == 4'(BLOCK_WORDS - 1));
      round_done = (round_ff == 7'(ROUND_COUNT - 1));
      emit_load  = (state_ff == BK_EMIT) && (!rsp_valid_ff || rsp_ready);
      emit_done  = emit_load && (idx_ff == 3'(DIGEST_WORDS - 1));
      rsp_valid  = rsp_valid_ff;
      rsp_data   = rsp_data_ff;

      priority if (round_ff < 7'd20) stage = ST_CH;
      else if (round_ff < 7'd40)     stage = ST_PAR1;
      else if (round_ff < 7'd60)     stage = ST_MAJ;
      else                           stage = ST_PAR2;

      sched_x = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wt      = (round_ff < 7'(BLOCK_WORDS)) ? w_ff[0] : {sched_x[30:0], sched_x[31]};
      tmp     = {wv_ff[0][26:0], wv_ff[0][31:27]} + round_f(stage, wv_ff[1], wv_ff[2], wv_ff[3])
                + wv_ff[4] + round_k(stage) + wt;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_LOAD:  if (block_full) state_in = BK_ROUND;
         BK_ROUND: if (round_done) state_in = BK_ADD;
         BK_ADD:   state_in = final_ff ? BK_EMIT : BK_LOAD;
         BK_EMIT:  if (emit_done) state_in = BK_LOAD;
      endcase
   end

   // Datapath next values
   always_comb begin
      w_in         = w_ff;
      wv_in        = wv_ff;
      chain_in     = chain_ff;
      wcnt_in      = wcnt_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         BK_LOAD: begin
            if (load) begin
               for (int i = 0; i < BLOCK_WORDS - 1; i++) w_in[i] = w_ff[i+1];
               w_in[BLOCK_WORDS-1] = pop_data.word;
               wcnt_in  = wcnt_ff + 4'd1;
               final_in = pop_data.final_word;
            end
            if (block_full) begin
               wv_in    = chain_ff;
               round_in = '0;
            end
         end
         BK_ROUND: begin
            // advance the rolling schedule window and the working variables
            for (int i = 0; i < BLOCK_WORDS - 1; i++) w_in[i] = w_ff[i+1];
            w_in[BLOCK_WORDS-1] = wt;
            wv_in[0] = tmp;
            wv_in[1] = wv_ff[0];
            wv_in[2] = {wv_ff[1][1:0], wv_ff[1][31:2]};
            wv_in[3] = wv_ff[2];
            wv_in[4] = wv_ff[3];
            round_in = round_ff + 7'd1;
         end
         BK_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) chain_in[i] = chain_ff[i] + wv_ff[i];
            idx_in = '0;
         end
         BK_EMIT: begin
            if (emit_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = chain_ff[idx_ff];
               rsp_data_in.word_index  = idx_ff;
               rsp_data_in.last_word   = (idx_ff == 3'(DIGEST_WORDS - 1));
               idx_in                  = idx_ff + 3'd1;
            end
            if (emit_done) chain_in = H_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         wcnt_ff      <= '0;
         round_ff     <= '0;
         idx_ff       <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= H_INIT;
         wv_ff        <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         wv_ff        <= wv_in;
      end
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sv/sha1_hash_engine_unit.sv -----
// SHA-1 hash engine top level: front end, word queue and compression back end.
// Depends on sha1_pkg, sha1_front, sha1_queue and sha1_back.
//
// Streams a message one byte per transfer on the req_ channel and returns its
// 160-bit SHA-1 digest as five 32-bit words on the rsp_ channel, h0 first,
// with last_word set on the fifth. A transfer with end_of_message set closes
// the message (its byte, if byte_valid, is absorbed first); a transfer with
// end_of_message and no valid byte closes it too, so an empty message works.
// The front end takes one byte per cycle while the word queue has room and
// packs bytes big-endian into words; on end of message it inserts the 0x80
// marker, zero fill and the 64-bit bit length itself, one byte per cycle
// while the queue has room (no req_ transfers during that time). The back
// end drains 16 words, runs 80 rounds at one round per cycle and then folds
// the result into the chaining value in the BK_ADD state. During the rounds
// and that fold the front end can only fill the four-word queue (16 bytes)
// and then stalls; the other 48 bytes of the next block go in at one per
// cycle while the back end loads. Throughput is therefore set by the
// single-round compression loop and the queue depth. The digest leaves
// through an output register at one word per cycle when rsp_ready is held
// high; the engine then rearms for the next message on its own.
module sha1_hash_engine_unit #(
   parameter int QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sha1_pkg::sha1_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sha1_pkg::sha1_rsp_type rsp_data
);
   import sha1_pkg::*;

   // front end to queue
   logic          push_valid, push_ready;
   sha1_word_type push_data;
   // queue to back end
   logic          pop_valid, pop_ready;
   sha1_word_type pop_data;

   // Pack bytes, add padding and length
   sha1_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // Hold packed words while the back end compresses
   sha1_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Compress blocks and emit the digest
   sha1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
